### src/ckfr_pkg.sv
// Shared types and constants for the checksummed frame receiver.
// Used by ckfr_ctrl, ckfr_dp and checksummed_frame_receiver; no dependencies.
package ckfr_pkg;

  // Header bytes: 'A' then 'C'
  localparam logic [7:0] HDR_FIRST  = 8'h41;
  localparam logic [7:0] HDR_SECOND = 8'h43;

  // At most four payload words are reported per frame
  localparam int unsigned MAX_WORDS = 4;
  localparam int unsigned WCNT_W    = 3;

  // Result kinds
  localparam logic KIND_WORD  = 1'b0;
  localparam logic KIND_ALIVE = 1'b1;

  typedef enum logic [3:0] {
    ST_HUNT,
    ST_HDR_C,
    ST_TYPE,
    ST_LEN,
    ST_PAYLOAD,
    ST_TRAIL1,
    ST_TRAIL2,
    ST_EMIT_READ,
    ST_EMIT_WORD,
    ST_EMIT_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr_sums;
    logic add_sums;
    logic load_type;
    logic load_len;
    logic store_byte;
    logic word_clr;
    logic word_inc;
    logic load_word;
    logic load_done;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_a;
    logic is_c;
    logic len_ok;
    logic len_zero;
    logic payload_end;
    logic sum1_ok;
    logic sum2_ok;
    logic has_words;
    logic last_word;
    logic out_free;
  } sts_t;

endpackage

### src/checksummed_frame_receiver.sv
// Top level of the checksummed frame receiver: joins controller and datapath.
// Depends on ckfr_pkg, ckfr_ctrl and ckfr_dp.
//
//   channel | valid         | stall         | payload
//   --------+---------------+---------------+-------------------------------------
//   byte    | byte_valid    | byte_stall    | rx_byte
//   result  | result_valid  | result_stall  | kind word_index word_value frame_type last
//
// Header, type, length, payload and trailer bytes are taken one per cycle.
// After a checking second trailer byte the input is held while results go out:
// a read state (registered read of the word store) and a word state for each
// payload word, then a done state for the frame-accepted transaction.
// rst is synchronous and clears control state; the payload store needs no reset.
// A stalled result holds the register and the sequencer waits on it.
module checksummed_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  rx_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        kind,
  output logic [1:0]  word_index,
  output logic [31:0] word_value,
  output logic [7:0]  frame_type,
  output logic        last
);

  ckfr_pkg::cmd_t cmd;
  ckfr_pkg::sts_t sts;

  // Frame parsing and result sequencing
  ckfr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Sums, store and result register
  ckfr_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .word_index   (word_index),
    .word_value   (word_value),
    .frame_type   (frame_type),
    .last         (last)
  );

`ifndef ASSERT_OFF
  // A new result only appears while the byte input is held for sequencing
  a_result_during_hold : assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(byte_stall))
    else $error("result appeared outside result sequencing");

  // The final result of a frame is always the frame-accepted one
  a_last_is_alive : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last == kind))
    else $error("last flag does not match result kind");

  // Controller never loads a word and the accept result together
  a_single_load : assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_word && cmd.load_done))
    else $error("two result loads in one cycle");
`endif

endmodule

### src/ckfr_dp.sv
// Datapath of the checksummed frame receiver: Fletcher sums, frame fields,
// payload word store and result register. Depends on ckfr_pkg.
module ckfr_dp #(
  parameter int unsigned MAX_PAYLOAD = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           rx_byte,
  input  ckfr_pkg::cmd_t       cmd,
  output ckfr_pkg::sts_t       sts,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 kind,
  output logic [1:0]           word_index,
  output logic [31:0]          word_value,
  output logic [7:0]           frame_type
  , output logic               last
);

  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned WORDS =
    (MAX_PAYLOAD / 4 < ckfr_pkg::MAX_WORDS) ? MAX_PAYLOAD / 4 : ckfr_pkg::MAX_WORDS;
  localparam int unsigned STORE_BYTES = 4 * WORDS;
  localparam int unsigned WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [7:0]                    sum_first;
  logic [7:0]                    sum_second;
  logic [7:0]                    sum_first_next;
  logic [7:0]                    type_reg;
  logic [LEN_W-1:0]              length_reg;
  logic [LEN_W-1:0]              sub_count;
  logic [ckfr_pkg::WCNT_W-1:0]   word_cnt;
  logic [ckfr_pkg::WCNT_W-1:0]   num_words;
  logic [LEN_W-1:0]              len_words;
  logic [31:0]                   mem [0:WORDS-1];
  logic [31:0]                   rd_data;
  logic [LEN_W-1:0]              row_full;
  logic [WORD_AW-1:0]            wr_row;
  logic [1:0]                    wr_lane;
  logic                          out_free;

  assign sum_first_next = sum_first + rx_byte;

  // Fletcher sums; the second accumulates the updated first
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_first  <= '0;
      sum_second <= '0;
    end else if (cmd.clr_sums) begin
      sum_first  <= '0;
      sum_second <= '0;
    end else if (cmd.add_sums) begin
      sum_first  <= sum_first_next;
      sum_second <= sum_second + sum_first_next;
    end
  end

  // Frame type, length and payload byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      type_reg   <= '0;
      length_reg <= '0;
      sub_count  <= '0;
    end else begin
      if (cmd.load_type) begin
        type_reg <= rx_byte;
      end
      if (cmd.load_len) begin
        length_reg <= rx_byte[LEN_W-1:0];
        sub_count  <= '0;
      end else if (cmd.store_byte) begin
        sub_count <= sub_count + 1'b1;
      end
    end
  end

  // Payload store: bytes packed little-endian into words
  assign row_full = sub_count >> 2;
  assign wr_row   = row_full[WORD_AW-1:0];
  assign wr_lane  = sub_count[1:0];

  always_ff @(posedge clk) begin
    if (cmd.store_byte && (sub_count < LEN_W'(STORE_BYTES))) begin
      mem[wr_row][{wr_lane, 3'b000} +: 8] <= rx_byte;
    end
    rd_data <= mem[word_cnt[WORD_AW-1:0]];
  end

  // Word counter for emission
  always_ff @(posedge clk) begin
    if (rst) begin
      word_cnt <= '0;
    end else if (cmd.word_clr) begin
      word_cnt <= '0;
    end else if (cmd.word_inc) begin
      word_cnt <= word_cnt + 1'b1;
    end
  end

  assign len_words = length_reg >> 2;
  assign num_words = (len_words >= LEN_W'(WORDS)) ? ckfr_pkg::WCNT_W'(WORDS)
                                                   : ckfr_pkg::WCNT_W'(len_words);

  // Result register: load a word or the frame-accepted result, drop on take
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_word || cmd.load_done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      kind       <= ckfr_pkg::KIND_WORD;
      word_index <= word_cnt[1:0];
      word_value <= rd_data;
      frame_type <= type_reg;
      last       <= 1'b0;
    end else if (cmd.load_done) begin
      kind       <= ckfr_pkg::KIND_ALIVE;
      word_index <= '0;
      word_value <= '0;
      frame_type <= type_reg;
      last       <= 1'b1;
    end
  end

  // Status toward the controller
  always_comb begin
    sts.is_a        = (rx_byte == ckfr_pkg::HDR_FIRST);
    sts.is_c        = (rx_byte == ckfr_pkg::HDR_SECOND);
    sts.len_ok      = (rx_byte <= 8'(MAX_PAYLOAD));
    sts.len_zero    = (rx_byte == 8'd0);
    sts.payload_end = ((sub_count + 1'b1) == length_reg);
    sts.sum1_ok     = (rx_byte == sum_first);
    sts.sum2_ok     = (rx_byte == sum_second);
    sts.has_words   = (num_words != '0);
    sts.last_word   = ((word_cnt + 1'b1) == num_words);
    sts.out_free    = out_free;
  end

endmodule

### src/ckfr_ctrl.sv
// Controller of the checksummed frame receiver: frame parsing and result
// sequencing state machine. Depends on ckfr_pkg.
module ckfr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  ckfr_pkg::sts_t   sts,
  output ckfr_pkg::cmd_t   cmd
);

  ckfr_pkg::state_t state;
  ckfr_pkg::state_t state_next;
  logic             take;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ckfr_pkg::ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  // Hold input while results are being sequenced out
  assign byte_stall = (state inside {ckfr_pkg::ST_EMIT_READ, ckfr_pkg::ST_EMIT_WORD,
                                     ckfr_pkg::ST_EMIT_DONE});
  assign take = byte_valid && !byte_stall;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ckfr_pkg::ST_HUNT: begin
        if (take && sts.is_a) begin
          state_next = ckfr_pkg::ST_HDR_C;
        end
      end
      ckfr_pkg::ST_HDR_C: begin
        if (take) begin
          if (sts.is_c) begin
            cmd.clr_sums = 1'b1;
            state_next   = ckfr_pkg::ST_TYPE;
          end else begin
            state_next = ckfr_pkg::ST_HUNT;
          end
        end
      end
      ckfr_pkg::ST_TYPE: begin
        if (take) begin
          cmd.load_type = 1'b1;
          cmd.add_sums  = 1'b1;
          state_next    = ckfr_pkg::ST_LEN;
        end
      end
      ckfr_pkg::ST_LEN: begin
        if (take) begin
          if (sts.len_ok) begin
            cmd.load_len = 1'b1;
            cmd.add_sums = 1'b1;
            state_next   = sts.len_zero ? ckfr_pkg::ST_TRAIL1 : ckfr_pkg::ST_PAYLOAD;
          end else begin
            state_next = ckfr_pkg::ST_HUNT;
          end
        end
      end
      ckfr_pkg::ST_PAYLOAD: begin
        if (take) begin
          cmd.store_byte = 1'b1;
          cmd.add_sums   = 1'b1;
          if (sts.payload_end) begin
            state_next = ckfr_pkg::ST_TRAIL1;
          end
        end
      end
      ckfr_pkg::ST_TRAIL1: begin
        if (take) begin
          state_next = sts.sum1_ok ? ckfr_pkg::ST_TRAIL2 : ckfr_pkg::ST_HUNT;
        end
      end
      ckfr_pkg::ST_TRAIL2: begin
        if (take) begin
          if (sts.sum2_ok) begin
            cmd.word_clr = 1'b1;
            state_next   = sts.has_words ? ckfr_pkg::ST_EMIT_READ : ckfr_pkg::ST_EMIT_DONE;
          end else begin
            state_next = ckfr_pkg::ST_HUNT;
          end
        end
      end
      ckfr_pkg::ST_EMIT_READ: begin
        state_next = ckfr_pkg::ST_EMIT_WORD;
      end
      ckfr_pkg::ST_EMIT_WORD: begin
        if (sts.out_free) begin
          cmd.load_word = 1'b1;
          cmd.word_inc  = 1'b1;
          state_next    = sts.last_word ? ckfr_pkg::ST_EMIT_DONE : ckfr_pkg::ST_EMIT_READ;
        end
      end
      ckfr_pkg::ST_EMIT_DONE: begin
        if (sts.out_free) begin
          cmd.load_done = 1'b1;
          state_next    = ckfr_pkg::ST_HUNT;
        end
      end
      default: begin
        state_next = ckfr_pkg::ST_HUNT;
      end
    endcase
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for checksummed_frame_receiver: drives serial bytes, predicts the payload
// words and frame-accepted transactions, and checks every result. Depends on ckfr_pkg.
module tb;

  localparam int CLK_HALF = 4;
  localparam int PAYLOAD_MAX = 16;
  localparam int RANDOM_BYTES = 185;
  // Set far above the length of the slowest run
  localparam int CYCLE_LIMIT = 100000;
  // Margin for a frame's output, plus receiver stalls
  localparam int DRAIN_CYCLES = 50;
  localparam int PRINT_CAP = 40;

  typedef enum logic [1:0] {
    FILL_NONE,
    FILL_SUM1,
    FILL_SUM2
  } fill_t;

  typedef enum logic [2:0] {
    RXP_HUNT,
    RXP_TYPE,
    RXP_LEN,
    RXP_BODY,
    RXP_TRAILER
  } rx_phase_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PULSED
  } stall_mode_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  word_index;
    logic [31:0] word_value;
    logic [7:0]  frame_type;
    logic        last;
  } frame_result_t;

  // One directed byte; typed rows carry their own expected outcome
  typedef struct packed {
    logic [7:0] data;
    fill_t      fill;
    logic       typed;
    logic       typed_alive;
    logic [7:0] typed_type;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 30;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // 'A' after 'A' restarts the hunt, so the 'C' is ignored
    '{ckfr_pkg::HDR_FIRST,  FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{ckfr_pkg::HDR_FIRST,  FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{ckfr_pkg::HDR_SECOND, FILL_NONE, 1'b0, 1'b0, 8'h00},
    // zero length frame, type 0xFF: sums are FF and FE
    '{ckfr_pkg::HDR_FIRST,  FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{ckfr_pkg::HDR_SECOND, FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'hFF,                FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'h00,                FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'hFF,                FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'hFE,                FILL_NONE, 1'b1, 1'b1, 8'hFF},
    // length 17 aborts the frame
    '{ckfr_pkg::HDR_FIRST,  FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{ckfr_pkg::HDR_SECOND, FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'h00,                FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'h11,                FILL_NONE, 1'b1, 1'b0, 8'h00},
    // second trailer byte wrong: frame dropped silently
    '{ckfr_pkg::HDR_FIRST,  FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{ckfr_pkg::HDR_SECOND, FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'h00,                FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'h00,                FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'h00,                FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'h01,                FILL_NONE, 1'b1, 1'b0, 8'h00},
    // five payload bytes: one word, trailing byte not emitted
    '{ckfr_pkg::HDR_FIRST,  FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{ckfr_pkg::HDR_SECOND, FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'h5A,                FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'h05,                FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'hFF,                FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'h00,                FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'h80,                FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'h01,                FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'h7F,                FILL_NONE, 1'b0, 1'b0, 8'h00},
    '{8'h00,                FILL_SUM1, 1'b0, 1'b0, 8'h00},
    '{8'h00,                FILL_SUM2, 1'b0, 1'b0, 8'h00}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        kind;
  logic [1:0]  word_index;
  logic [31:0] word_value;
  logic [7:0]  frame_type;
  logic        last;

  // Receiver model state
  rx_phase_t  rx_phase;
  logic       hdr_seen;
  logic       trail_half;
  logic [4:0] body_count;
  logic [4:0] body_len;
  logic [7:0] type_q;
  logic [7:0] body_bytes [PAYLOAD_MAX];
  logic [7:0] fl_sum_a;
  logic [7:0] fl_sum_b;

  frame_result_t awaited_results [$];
  frame_result_t fresh_results [$];

  // Outcome override of the byte on the link, set by the sender
  logic       row_typed = 1'b0;
  logic       row_alive = 1'b0;
  logic [7:0] row_type = 8'h00;

  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int stall_tick = 0;
  stall_mode_t stall_mode = RX_FREE;

  checksummed_frame_receiver #(
    .MAX_PAYLOAD(PAYLOAD_MAX)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .rx_byte(rx_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kind(kind),
    .word_index(word_index),
    .word_value(word_value),
    .frame_type(frame_type),
    .last(last)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] exp_v);
    if (mismatches < PRINT_CAP)
      $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got_v, exp_v);
    mismatches++;
  endtask

  task automatic clear_receiver_model();
    rx_phase = RXP_HUNT;
    hdr_seen = 1'b0;
    trail_half = 1'b0;
    body_count = '0;
    body_len = '0;
    type_q = '0;
    fl_sum_a = '0;
    fl_sum_b = '0;
  endtask

  task automatic add_to_sums(input logic [7:0] b);
    fl_sum_a = fl_sum_a + b;
    fl_sum_b = fl_sum_b + fl_sum_a;
  endtask

  // Advance the receiver model by one byte; queue what it emits in fresh_results
  task automatic track_frame_byte(input logic [7:0] b);
    int w;
    frame_result_t r;
    fresh_results.delete();
    case (rx_phase)
      RXP_HUNT: begin
        if (!hdr_seen) begin
          if (b == ckfr_pkg::HDR_FIRST) hdr_seen = 1'b1;
        end else if (b == ckfr_pkg::HDR_SECOND) begin
          rx_phase = RXP_TYPE;
          hdr_seen = 1'b0;
          fl_sum_a = '0;
          fl_sum_b = '0;
        end else begin
          hdr_seen = 1'b0;
        end
      end
      RXP_TYPE: begin
        type_q = b;
        add_to_sums(b);
        rx_phase = RXP_LEN;
      end
      RXP_LEN: begin
        if (int'(b) > PAYLOAD_MAX) begin
          rx_phase = RXP_HUNT;
        end else begin
          body_len = b[4:0];
          add_to_sums(b);
          body_count = '0;
          trail_half = 1'b0;
          rx_phase = (b == 8'h00) ? RXP_TRAILER : RXP_BODY;
        end
      end
      RXP_BODY: begin
        body_bytes[body_count] = b;
        add_to_sums(b);
        body_count = body_count + 5'd1;
        if (body_count >= body_len) begin
          trail_half = 1'b0;
          rx_phase = RXP_TRAILER;
        end
      end
      RXP_TRAILER: begin
        if (!trail_half) begin
          if (b != fl_sum_a) rx_phase = RXP_HUNT;
          else trail_half = 1'b1;
        end else begin
          if (b == fl_sum_b) begin
            // emit complete words, then the frame-accepted transaction
            for (w = 0; w < int'(body_len) / 4; w++) begin
              r.kind = ckfr_pkg::KIND_WORD;
              r.word_index = 2'(w);
              r.word_value = {body_bytes[4*w+3], body_bytes[4*w+2],
                              body_bytes[4*w+1], body_bytes[4*w]};
              r.frame_type = type_q;
              r.last = 1'b0;
              fresh_results.push_back(r);
            end
            r.kind = ckfr_pkg::KIND_ALIVE;
            r.word_index = '0;
            r.word_value = '0;
            r.frame_type = type_q;
            r.last = 1'b1;
            fresh_results.push_back(r);
          end
          rx_phase = RXP_HUNT;
        end
      end
      default: rx_phase = RXP_HUNT;
    endcase
  endtask

  task automatic check_result();
    frame_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("unexpected result, word_value", word_value, 32'h0);
    end else begin
      want = awaited_results.pop_front();
      if (kind !== want.kind) report_mismatch("kind", kind, want.kind);
      if (word_index !== want.word_index)
        report_mismatch("word_index", word_index, want.word_index);
      if (word_value !== want.word_value)
        report_mismatch("word_value", word_value, want.word_value);
      if (frame_type !== want.frame_type)
        report_mismatch("frame_type", frame_type, want.frame_type);
      if (last !== want.last) report_mismatch("last", last, want.last);
    end
  endtask

  // Check results, then predict from the accepted byte, both at the rising edge
  always @(posedge clk) begin
    frame_result_t alive;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (rst) begin
      clear_receiver_model();
    end else begin
      if (result_valid && !result_stall) check_result();
      if (byte_valid && !byte_stall) begin
        track_frame_byte(rx_byte);
        if (row_typed) begin
          if (row_alive) begin
            alive.kind = ckfr_pkg::KIND_ALIVE;
            alive.word_index = '0;
            alive.word_value = '0;
            alive.frame_type = row_type;
            alive.last = 1'b1;
            awaited_results.push_back(alive);
          end
        end else begin
          foreach (fresh_results[k]) awaited_results.push_back(fresh_results[k]);
        end
      end
    end
  end

  // Receiver stall: pattern chosen at random, switched periodically by the stall tick
  always @(negedge clk) begin
    if (stall_tick % 48 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      RX_FREE:   result_stall <= 1'b0;
      RX_LIGHT:  result_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY:  result_stall <= ($urandom_range(0, 9) < 6);
      default:   result_stall <= (stall_tick % 16) < 8;
    endcase
    stall_tick++;
  end

  // Send one byte in bursts with random gaps; trailer bytes are filled from the sums
  task automatic send_byte(input logic [7:0] value, input fill_t fill, input logic [7:0] flip,
                           input logic typed, input logic typed_alive,
                           input logic [7:0] typed_type);
    int gap;
    logic [7:0] data;
    @(negedge clk);
    if (burst_left == 0) begin
      byte_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    case (fill)
      FILL_SUM1: data = fl_sum_a ^ flip;
      FILL_SUM2: data = fl_sum_b ^ flip;
      default:   data = value;
    endcase
    row_typed = typed;
    row_alive = typed_alive;
    row_type = typed_type;
    byte_valid <= 1'b1;
    rx_byte <= data;
    do @(posedge clk); while (byte_stall);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic put_byte(input logic [7:0] value);
    send_byte(value, FILL_NONE, 8'h00, 1'b0, 1'b0, 8'h00);
  endtask

  // Mostly well-formed frames; the rest is noise, broken headers, long lengths, bad sums
  task automatic send_random_frame(ref int sent);
    int pick;
    int len;
    int i;
    logic [7:0] b;
    logic [7:0] flip1;
    logic [7:0] flip2;
    pick = $urandom_range(0, 99);
    flip1 = 8'h00;
    flip2 = 8'h00;
    if (pick < 6) begin
      len = $urandom_range(1, 4);
      for (i = 0; i < len; i++) put_byte(8'($urandom_range(0, 255)));
      sent += len;
    end else if (pick < 12) begin
      b = 8'($urandom_range(0, 255));
      if (b == ckfr_pkg::HDR_SECOND) b = ckfr_pkg::HDR_FIRST;
      put_byte(ckfr_pkg::HDR_FIRST);
      put_byte(b);
      sent += 2;
    end else if (pick < 18) begin
      put_byte(ckfr_pkg::HDR_FIRST);
      put_byte(ckfr_pkg::HDR_SECOND);
      put_byte(8'($urandom_range(0, 255)));
      put_byte(8'($urandom_range(PAYLOAD_MAX + 1, 255)));
      sent += 4;
    end else begin
      if (pick < 24) flip1 = 8'($urandom_range(1, 255));
      else if (pick < 30) flip2 = 8'($urandom_range(1, 255));
      case ($urandom_range(0, 3))
        0:       len = PAYLOAD_MAX;
        1:       len = 4 * $urandom_range(0, PAYLOAD_MAX / 4);
        default: len = $urandom_range(0, PAYLOAD_MAX);
      endcase
      put_byte(ckfr_pkg::HDR_FIRST);
      put_byte(ckfr_pkg::HDR_SECOND);
      put_byte(8'($urandom_range(0, 255)));
      put_byte(8'(len));
      for (i = 0; i < len; i++) put_byte(8'($urandom_range(0, 255)));
      send_byte(8'h00, FILL_SUM1, flip1, 1'b0, 1'b0, 8'h00);
      send_byte(8'h00, FILL_SUM2, flip2, 1'b0, 1'b0, 8'h00);
      sent += len + 6;
    end
  endtask

  initial begin
    int i;
    int sent;
    sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows
    for (i = 0; i < DIRECTED_ROWS; i++)
      send_byte(DIRECTED[i].data, DIRECTED[i].fill, 8'h00, DIRECTED[i].typed,
                DIRECTED[i].typed_alive, DIRECTED[i].typed_type);

    // random frames
    while (sent < RANDOM_BYTES) send_random_frame(sent);

    @(negedge clk);
    byte_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
